### sv/local_peak_finder_3x3_defines.svh
// Assertion macros shared by the local peak finder RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef LOCAL_PEAK_FINDER_3X3_DEFINES_SVH
`define LOCAL_PEAK_FINDER_3X3_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LPF3_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lpf3 check failed (same cycle)");

// Next-cycle implication, disabled during reset.
`define LPF3_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lpf3 check failed (next cycle)");

`endif

### sv/lpf3_pkg.sv
// Shared constants, register codes and result type of the local peak finder.
// No dependencies; used by local_peak_finder_3x3 and its bench.
package lpf3_pkg;

   // Defaults for top-level parameters
   localparam int MAX_WIDTH_DEF   = 2048;
   localparam int PIXEL_BITS_DEF  = 16;
   localparam int BUDGET_BITS_DEF = 12;

   // Fixed field widths
   localparam int COORD_BITS     = 11;
   localparam int SLOT_BITS      = 12;
   localparam int WIDTH_REG_BITS = 12;
   localparam int THRESH_BITS    = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MIN_WIDTH      = 3;

   localparam logic [COORD_BITS-1:0] ROW_LIMIT = 11'd2047;

   // Register reset values
   localparam logic [WIDTH_REG_BITS-1:0]    RST_IMAGE_WIDTH = 12'd640;
   localparam logic [COORD_BITS-1:0]        RST_X_FIRST     = 11'd1;
   localparam logic [COORD_BITS-1:0]        RST_X_LAST      = 11'd638;
   localparam logic [COORD_BITS-1:0]        RST_Y_FIRST     = 11'd1;
   localparam logic [COORD_BITS-1:0]        RST_Y_LAST      = 11'd478;
   localparam logic signed [THRESH_BITS-1:0] RST_THRESHOLD  = 16'sd0;
   localparam logic [SLOT_BITS-1:0]         RST_BUDGET      = 12'd256;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_REGION_X_FIRST = 3'd1,
      CSR_REGION_X_LAST  = 3'd2,
      CSR_REGION_Y_FIRST = 3'd3,
      CSR_REGION_Y_LAST  = 3'd4,
      CSR_PEAK_THRESHOLD = 3'd5,
      CSR_PEAK_BUDGET    = 3'd6
   } csr_index_type;

   typedef enum logic {
      KIND_PEAK    = 1'b0,
      KIND_SUMMARY = 1'b1
   } result_kind_type;

   typedef struct packed {
      result_kind_type        kind;
      logic [COORD_BITS-1:0]  x;
      logic [COORD_BITS-1:0]  y;
      logic [SLOT_BITS-1:0]   slots;
      logic                   overflowed;
      logic                   last;
   } result_type;

endpackage

### sv/local_peak_finder_3x3.sv
// Local peak finder: one pixel item per clock in raster order, sustained. An item
// passes stage 1 and stage 2 registers into the result queue; the one-read, one-write
// line memory and the 3x3 window run at one pixel a cycle, and input is held off
// only while the four-entry result queue holds more than two results. A pixel that
// finishes a peak window and ends the frame yields two results, peak then summary.
// The line memory is not cleared after reset; its unwritten entries only feed rows
// 0 and 1 of a frame, which are never tested.
// Depends on lpf3_pkg and local_peak_finder_3x3_defines.svh.
`include "local_peak_finder_3x3_defines.svh"

module local_peak_finder_3x3 #(
   parameter int MAX_WIDTH   = lpf3_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS  = lpf3_pkg::PIXEL_BITS_DEF,
   parameter int BUDGET_BITS = lpf3_pkg::BUDGET_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input items
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [PIXEL_BITS-1:0]           req_pixel_value,
   input  logic                                   req_frame_end,
   // result items
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_result_kind,
   output logic [lpf3_pkg::COORD_BITS-1:0]        rsp_peak_x,
   output logic [lpf3_pkg::COORD_BITS-1:0]        rsp_peak_y,
   output logic [lpf3_pkg::SLOT_BITS-1:0]         rsp_slots_left,
   output logic                                   rsp_overflowed,
   output logic                                   rsp_last,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [lpf3_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [lpf3_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW    = (CW + 1 > lpf3_pkg::WIDTH_REG_BITS) ? CW + 1
                                                              : lpf3_pkg::WIDTH_REG_BITS;
   localparam int RW    = (CW > lpf3_pkg::COORD_BITS) ? CW : lpf3_pkg::COORD_BITS;
   localparam int TW    = (PIXEL_BITS > lpf3_pkg::THRESH_BITS) ? PIXEL_BITS
                                                               : lpf3_pkg::THRESH_BITS;
   localparam int LB    = 2 * PIXEL_BITS;
   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = PW + 1;

   localparam logic [EW-1:0] MAX_W_EXT = EW'(MAX_WIDTH);
   localparam logic [EW-1:0] MIN_W_EXT = EW'(lpf3_pkg::MIN_WIDTH);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [lpf3_pkg::WIDTH_REG_BITS-1:0]    width_ff;
   logic [lpf3_pkg::COORD_BITS-1:0]        x_first_ff, x_last_ff, y_first_ff, y_last_ff;
   logic signed [lpf3_pkg::THRESH_BITS-1:0] thresh_ff;
   logic [lpf3_pkg::SLOT_BITS-1:0]         budget_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= lpf3_pkg::RST_IMAGE_WIDTH;
         x_first_ff    <= lpf3_pkg::RST_X_FIRST;
         x_last_ff     <= lpf3_pkg::RST_X_LAST;
         y_first_ff    <= lpf3_pkg::RST_Y_FIRST;
         y_last_ff     <= lpf3_pkg::RST_Y_LAST;
         thresh_ff     <= lpf3_pkg::RST_THRESHOLD;
         budget_cfg_ff <= lpf3_pkg::RST_BUDGET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lpf3_pkg::CSR_IMAGE_WIDTH:
               width_ff <= csr_wdata[lpf3_pkg::WIDTH_REG_BITS-1:0];
            lpf3_pkg::CSR_REGION_X_FIRST:
               x_first_ff <= csr_wdata[lpf3_pkg::COORD_BITS-1:0];
            lpf3_pkg::CSR_REGION_X_LAST:
               x_last_ff <= csr_wdata[lpf3_pkg::COORD_BITS-1:0];
            lpf3_pkg::CSR_REGION_Y_FIRST:
               y_first_ff <= csr_wdata[lpf3_pkg::COORD_BITS-1:0];
            lpf3_pkg::CSR_REGION_Y_LAST:
               y_last_ff <= csr_wdata[lpf3_pkg::COORD_BITS-1:0];
            lpf3_pkg::CSR_PEAK_THRESHOLD:
               thresh_ff <= csr_wdata[lpf3_pkg::THRESH_BITS-1:0];
            lpf3_pkg::CSR_PEAK_BUDGET:
               budget_cfg_ff <= csr_wdata[lpf3_pkg::SLOT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the row stride into the supported range
   logic [EW-1:0] width_eff;
   always_comb begin
      if (EW'(width_ff) < MIN_W_EXT) begin
         width_eff = MIN_W_EXT;
      end else if (EW'(width_ff) > MAX_W_EXT) begin
         width_eff = MAX_W_EXT;
      end else begin
         width_eff = EW'(width_ff);
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control and result queue occupancy
   // ------------------------------------------------------------------
   logic [NW-1:0] q_cnt_ff, q_cnt_in;
   logic          adv;
   logic          acc;

   assign adv       = (q_cnt_ff <= NW'(DEPTH - 2));
   assign req_ready = adv;
   assign acc       = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Stage 0: raster counters, line memory read
   // ------------------------------------------------------------------
   logic [CW-1:0]                   col_ff, col_in, col_cur;
   logic [lpf3_pkg::COORD_BITS-1:0] row_ff, row_in;
   logic [CW:0]                     col_inc;
   logic                            row_wrap;
   logic                            frame_start;

   always_comb begin
      col_cur     = (EW'(col_ff) >= width_eff) ? '0 : col_ff;
      frame_start = (col_ff == '0) && (row_ff == '0);
      col_inc     = {1'b0, col_cur} + (CW+1)'(1);
      row_wrap    = (EW'(col_inc) >= width_eff);
      col_in      = row_wrap ? '0 : col_inc[CW-1:0];
      row_in      = (row_wrap && (row_ff != lpf3_pkg::ROW_LIMIT))
                    ? row_ff + lpf3_pkg::COORD_BITS'(1) : row_ff;
      if (req_frame_end) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line memory: upper row in the high half, middle row in the low half
   logic [LB-1:0] line_mem [MAX_WIDTH];
   logic [LB-1:0] rd_ff;
   logic [LB-1:0] fwd_data_ff;
   logic          fwd_hit_ff;

   // Stage 1 registers
   logic                            s1_valid_ff;
   logic signed [PIXEL_BITS-1:0]    s1_pix_ff;
   logic                            s1_fend_ff;
   logic                            s1_fs_ff;
   logic [CW-1:0]                   s1_col_ff;
   logic [lpf3_pkg::COORD_BITS-1:0] s1_row_ff;

   logic                            s1_wr;
   logic [LB-1:0]                   s1_line;
   logic signed [PIXEL_BITS-1:0]    s1_up, s1_mid;
   logic [LB-1:0]                   s1_wdata;

   assign s1_wr    = s1_valid_ff && adv;
   assign s1_line  = fwd_hit_ff ? fwd_data_ff : rd_ff;
   assign s1_up    = s1_line[LB-1:PIXEL_BITS];
   assign s1_mid   = s1_line[PIXEL_BITS-1:0];
   assign s1_wdata = {s1_mid, s1_pix_ff};

   // Read on accept; forward the write in flight when it hits the same column
   always_ff @(posedge clock) begin
      if (acc) begin
         rd_ff       <= line_mem[col_cur];
         fwd_data_ff <= s1_wdata;
      end
      if (s1_wr) begin
         line_mem[s1_col_ff] <= s1_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (acc) begin
         fwd_hit_ff <= s1_wr && (s1_col_ff == col_cur);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff  <= req_pixel_value;
         s1_fend_ff <= req_frame_end;
         s1_fs_ff   <= frame_start;
         s1_col_ff  <= col_cur;
         s1_row_ff  <= row_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: 3x3 window shift and peak test
   // ------------------------------------------------------------------
   logic signed [PIXEL_BITS-1:0]    win_ff [3][3];
   logic                            s2_valid_ff;
   logic                            s2_fend_ff;
   logic                            s2_fs_ff;
   logic [CW-1:0]                   s2_col_ff;
   logic [lpf3_pkg::COORD_BITS-1:0] s2_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= s1_up;
            win_ff[1][2] <= s1_mid;
            win_ff[2][2] <= s1_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         s2_fend_ff <= s1_fend_ff;
         s2_fs_ff   <= s1_fs_ff;
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
      end
   end

   // Budget and overflow state of the current frame
   logic [BUDGET_BITS-1:0] budget_ff, budget_in, budget_cur;
   logic                   ovf_ff, ovf_in, ovf_cur;

   logic [CW-1:0]                   cx;
   logic [lpf3_pkg::COORD_BITS-1:0] cy;
   logic                            in_region;
   logic                            is_peak;
   logic signed [TW-1:0]            center_ext;
   logic signed [TW-1:0]            thresh_ext;
   logic                            emit_peak;
   logic                            s2_go;

   assign s2_go = s2_valid_ff && adv;

   always_comb begin
      cx         = s2_col_ff - CW'(1);
      cy         = s2_row_ff - lpf3_pkg::COORD_BITS'(1);
      budget_cur = s2_fs_ff ? BUDGET_BITS'(budget_cfg_ff) : budget_ff;
      ovf_cur    = s2_fs_ff ? 1'b0 : ovf_ff;
      in_region  = (RW'(cx) >= RW'(x_first_ff)) && (RW'(cx) <= RW'(x_last_ff)) &&
                   (cy >= y_first_ff) && (cy <= y_last_ff);
      center_ext = TW'(win_ff[1][1]);
      thresh_ext = TW'(thresh_ff);
      is_peak    = (center_ext >= thresh_ext);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (win_ff[1][1] < win_ff[i][j]) begin
               is_peak = 1'b0;
            end
         end
      end
      is_peak = is_peak && in_region && !ovf_cur &&
                (s2_col_ff >= CW'(2)) && (s2_row_ff >= lpf3_pkg::COORD_BITS'(2));
      // spend one slot per peak; a peak with no slot left flags overflow
      emit_peak = is_peak && (budget_cur != '0);
      budget_in = emit_peak ? budget_cur - BUDGET_BITS'(1) : budget_cur;
      ovf_in    = ovf_cur || (is_peak && (budget_cur == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
         ovf_ff    <= 1'b0;
      end else if (s2_go) begin
         budget_ff <= budget_in;
         ovf_ff    <= ovf_in;
      end
   end

   // ------------------------------------------------------------------
   // Result queue: up to two pushes and one pop per cycle
   // ------------------------------------------------------------------
   lpf3_pkg::result_type peak_res, sum_res, push0, push1;
   logic [1:0]           n_push;

   always_comb begin
      peak_res.kind       = lpf3_pkg::KIND_PEAK;
      peak_res.x          = lpf3_pkg::COORD_BITS'(cx);
      peak_res.y          = cy;
      peak_res.slots      = lpf3_pkg::SLOT_BITS'(budget_in);
      peak_res.overflowed = 1'b0;
      peak_res.last       = 1'b0;
      sum_res.kind        = lpf3_pkg::KIND_SUMMARY;
      sum_res.x           = '0;
      sum_res.y           = '0;
      sum_res.slots       = lpf3_pkg::SLOT_BITS'(budget_in);
      sum_res.overflowed  = ovf_in;
      sum_res.last        = 1'b1;
      push0  = emit_peak ? peak_res : sum_res;
      push1  = sum_res;
      n_push = '0;
      if (s2_go) begin
         n_push = 2'({1'b0, emit_peak} + {1'b0, s2_fend_ff});
      end
   end

   lpf3_pkg::result_type q_mem_ff [DEPTH];
   logic [PW-1:0]        q_wr_ff, q_wr_in, q_rd_ff, q_rd_in;
   logic                 pop;

   assign pop      = rsp_valid && rsp_ready;
   assign q_wr_in  = q_wr_ff + PW'(n_push);
   assign q_rd_in  = q_rd_ff + PW'(pop);
   assign q_cnt_in = q_cnt_ff + NW'(n_push) - NW'(pop);

   always_ff @(posedge clock) begin
      if (n_push != '0) begin
         q_mem_ff[q_wr_ff] <= push0;
      end
      if (n_push == 2'd2) begin
         q_mem_ff[q_wr_ff + PW'(1)] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_in;
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   // Drive the result channel from the queue head
   lpf3_pkg::result_type head;
   assign head            = q_mem_ff[q_rd_ff];
   assign rsp_valid       = (q_cnt_ff != '0);
   assign rsp_result_kind = head.kind;
   assign rsp_peak_x      = head.x;
   assign rsp_peak_y      = head.y;
   assign rsp_slots_left  = head.slots;
   assign rsp_overflowed  = head.overflowed;
   assign rsp_last        = head.last;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   `LPF3_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, q_cnt_ff <= NW'(DEPTH))
   `LPF3_ASSERT_NEXT(a_stall_holds_window, clock, reset, !adv,
      $stable(win_ff[1][1]) && $stable(s2_valid_ff))
   `LPF3_ASSERT_NOW(a_overflow_source, clock, reset, $rose(ovf_ff),
      $past(s2_valid_ff && adv))
   `LPF3_ASSERT_NEXT(a_budget_no_gain, clock, reset, s2_go && !s2_fs_ff,
      budget_ff <= $past(budget_ff))

endmodule

### bench/local_peak_finder_3x3_test.sv
`timescale 1ns / 100ps
// Self-checking bench for local_peak_finder_3x3: random raster frames in, peak and summary
// items out, each checked field by field against a peak tracker kept in this file.
// Depends on lpf3_pkg and the local_peak_finder_3x3 RTL.
module local_peak_finder_3x3_test;

   localparam int IDLE_LIMIT      = 4000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_PIXELS   = 1050;
   localparam int PRESSURE_FRAMES = 40;
   localparam int WIDE_PIXELS     = 100;

   typedef logic signed [lpf3_pkg::PIXEL_BITS_DEF-1:0] pixel_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   pixel_type                             req_pixel_value = '0;
   logic                                  req_frame_end = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic                                  rsp_result_kind;
   logic [lpf3_pkg::COORD_BITS-1:0]       rsp_peak_x;
   logic [lpf3_pkg::COORD_BITS-1:0]       rsp_peak_y;
   logic [lpf3_pkg::SLOT_BITS-1:0]        rsp_slots_left;
   logic                                  rsp_overflowed;
   logic                                  rsp_last;
   logic                                  csr_write_en = 1'b0;
   lpf3_pkg::csr_index_type               csr_index = lpf3_pkg::CSR_IMAGE_WIDTH;
   logic [lpf3_pkg::CSR_DATA_BITS-1:0]    csr_wdata = '0;

   local_peak_finder_3x3 u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_peak_x      (rsp_peak_x),
      .rsp_peak_y      (rsp_peak_y),
      .rsp_slots_left  (rsp_slots_left),
      .rsp_overflowed  (rsp_overflowed),
      .rsp_last        (rsp_last),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Tracks line stores, window, counters and budget; holds the results still owed.
   class peak_tracker;
      logic [lpf3_pkg::WIDTH_REG_BITS-1:0]    width_reg;
      logic [lpf3_pkg::COORD_BITS-1:0]        x_first, x_last, y_first, y_last;
      logic signed [lpf3_pkg::THRESH_BITS-1:0] threshold;
      logic [lpf3_pkg::SLOT_BITS-1:0]         budget;
      pixel_type                              upper_line [lpf3_pkg::MAX_WIDTH_DEF];
      pixel_type                              middle_line [lpf3_pkg::MAX_WIDTH_DEF];
      pixel_type                              window [3][3];
      int unsigned                            col, row;
      logic [lpf3_pkg::SLOT_BITS-1:0]         slots;
      bit                                     overflow;
      lpf3_pkg::result_type                   owed_results [$];
      int mismatches, results_seen, peaks_seen, summaries_seen, overflowed_frames;
      int unsigned pixels_taken, deepest_row;

      function new();
         width_reg = lpf3_pkg::RST_IMAGE_WIDTH;
         x_first   = lpf3_pkg::RST_X_FIRST;
         x_last    = lpf3_pkg::RST_X_LAST;
         y_first   = lpf3_pkg::RST_Y_FIRST;
         y_last    = lpf3_pkg::RST_Y_LAST;
         threshold = lpf3_pkg::RST_THRESHOLD;
         budget    = lpf3_pkg::RST_BUDGET;
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         foreach (window[i, j]) window[i][j] = '0;
         col = 0;
         row = 0;
         slots = '0;
         overflow = 1'b0;
      endfunction

      function void set_register(lpf3_pkg::csr_index_type idx,
                                 logic [lpf3_pkg::CSR_DATA_BITS-1:0] data);
         case (idx)
            lpf3_pkg::CSR_IMAGE_WIDTH:    width_reg = data[lpf3_pkg::WIDTH_REG_BITS-1:0];
            lpf3_pkg::CSR_REGION_X_FIRST: x_first   = data[lpf3_pkg::COORD_BITS-1:0];
            lpf3_pkg::CSR_REGION_X_LAST:  x_last    = data[lpf3_pkg::COORD_BITS-1:0];
            lpf3_pkg::CSR_REGION_Y_FIRST: y_first   = data[lpf3_pkg::COORD_BITS-1:0];
            lpf3_pkg::CSR_REGION_Y_LAST:  y_last    = data[lpf3_pkg::COORD_BITS-1:0];
            lpf3_pkg::CSR_PEAK_THRESHOLD: threshold = data[lpf3_pkg::THRESH_BITS-1:0];
            lpf3_pkg::CSR_PEAK_BUDGET:    budget    = data[lpf3_pkg::SLOT_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Advance by one pixel and queue the results it owes.
      function void take_pixel(pixel_type value, logic frame_end);
         int unsigned w, c, r, cx, cy, i, j;
         pixel_type above, beside, center_px;
         bit is_peak;
         lpf3_pkg::result_type item;
         pixels_taken++;
         w = 32'(width_reg);
         if (w < lpf3_pkg::MIN_WIDTH) w = lpf3_pkg::MIN_WIDTH;
         if (w > lpf3_pkg::MAX_WIDTH_DEF) w = lpf3_pkg::MAX_WIDTH_DEF;
         // frame start: reload the budget, clear overflow
         if (col == 0 && row == 0) begin
            slots = budget;
            overflow = 1'b0;
         end
         if (col >= w) col = 0;
         c = col;
         r = row;
         // shift line stores and window by one column
         above  = upper_line[c];
         beside = middle_line[c];
         upper_line[c]  = beside;
         middle_line[c] = value;
         for (i = 0; i < 3; i++) begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
         end
         window[0][2] = above;
         window[1][2] = beside;
         window[2][2] = value;
         // test the window centered one row and one column back
         if (c >= 2 && r >= 2 && !overflow) begin
            cx = c - 1;
            cy = r - 1;
            if (cx >= x_first && cx <= x_last && cy >= y_first && cy <= y_last) begin
               center_px = window[1][1];
               is_peak = (center_px >= threshold);
               for (i = 0; i < 3; i++)
                  for (j = 0; j < 3; j++)
                     if (center_px < window[i][j]) is_peak = 1'b0;
               if (is_peak) begin
                  if (slots != 0) begin
                     slots = slots - 1'b1;
                     item.kind       = lpf3_pkg::KIND_PEAK;
                     item.x          = lpf3_pkg::COORD_BITS'(cx);
                     item.y          = lpf3_pkg::COORD_BITS'(cy);
                     item.slots      = slots;
                     item.overflowed = 1'b0;
                     item.last       = 1'b0;
                     owed_results.push_back(item);
                  end else begin
                     overflow = 1'b1;
                  end
               end
            end
         end
         col = c + 1;
         if (col >= w) begin
            col = 0;
            if (row < lpf3_pkg::ROW_LIMIT) row++;
         end
         // frame end: summary follows any peak, counters restart
         if (frame_end) begin
            item.kind       = lpf3_pkg::KIND_SUMMARY;
            item.x          = '0;
            item.y          = '0;
            item.slots      = slots;
            item.overflowed = overflow;
            item.last       = 1'b1;
            owed_results.push_back(item);
            col = 0;
            row = 0;
         end
      endfunction

      task report_mismatch(string what, int unsigned got_v, int unsigned want_v);
         mismatches++;
         $display("%0t ns, result %0d: %s is %0d, expected %0d",
                  $time, results_seen, what, got_v, want_v);
      endtask

      // Compare one accepted result with the oldest one owed.
      task take_result(lpf3_pkg::result_type got);
         lpf3_pkg::result_type want;
         results_seen++;
         if (owed_results.size() == 0) begin
            report_mismatch("result with none owed, kind", got.kind, 0);
            return;
         end
         want = owed_results.pop_front();
         if (got.kind != want.kind) report_mismatch("result_kind", got.kind, want.kind);
         if (got.x != want.x) report_mismatch("peak_x", got.x, want.x);
         if (got.y != want.y) report_mismatch("peak_y", got.y, want.y);
         if (got.slots != want.slots) report_mismatch("slots_left", got.slots, want.slots);
         if (got.overflowed != want.overflowed)
            report_mismatch("overflowed", got.overflowed, want.overflowed);
         if (got.last != want.last) report_mismatch("last", got.last, want.last);
         if (want.kind == lpf3_pkg::KIND_PEAK) begin
            peaks_seen++;
            if (want.y > deepest_row) deepest_row = want.y;
         end else begin
            summaries_seen++;
            if (want.overflowed) overflowed_frames++;
         end
      endtask

      task close_out();
         if (owed_results.size() != 0)
            report_mismatch("results never produced, count", owed_results.size(), 0);
      endtask

      function int owed();
         return owed_results.size();
      endfunction
   endclass

   peak_tracker tracker;
   bit          req_steady = 1'b1;
   bit          rsp_steady = 1'b0;
   int          holds_requested = 0;
   int          holds_done = 0;
   int          quiet_cycles = 0;
   int unsigned random_pixels = 0;

   always #1 clock = ~clock;

   // Idle length: mostly none, some short, a few long.
   function automatic int pick_gap(bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(99, 0);
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic int clamp_sample(int v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // Mostly a narrow band just above base so ties and peaks are common.
   function automatic pixel_type pick_pixel(int base, int spread);
      int roll, offset;
      roll = $urandom_range(99, 0);
      if (roll < 3) return 16'h8000;
      if (roll < 6) return 16'h7FFF;
      if (roll < 12) return pixel_type'($urandom);
      offset = $urandom_range(spread, 0);
      return pixel_type'(clamp_sample(base + offset));
   endfunction

   // Set some bits above the register field; the block keeps only the field.
   function automatic logic [lpf3_pkg::CSR_DATA_BITS-1:0] with_junk(int unsigned v, int bits);
      logic [lpf3_pkg::CSR_DATA_BITS-1:0] word;
      word = lpf3_pkg::CSR_DATA_BITS'(v);
      if ($urandom_range(3, 0) == 0)
         word = word | lpf3_pkg::CSR_DATA_BITS'($urandom << bits);
      return word;
   endfunction

   // Offer one pixel item and hold it until accepted.
   task automatic send_pixel(pixel_type value, logic frame_end);
      int gap;
      gap = pick_gap(req_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= value;
      req_frame_end   <= frame_end;
      do @(posedge clock); while (!req_ready);
      tracker.take_pixel(value, frame_end);
   endtask

   task automatic send_frame(int unsigned count, int base, int spread);
      int unsigned k;
      for (k = 1; k <= count; k++) send_pixel(pick_pixel(base, spread), k == count);
   endtask

   // Drop valid, wait for every owed result, then let the pipeline settle.
   task automatic drain_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.owed() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(lpf3_pkg::csr_index_type idx,
                            logic [lpf3_pkg::CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
   endtask

   task automatic apply_settings(int unsigned width, int unsigned xf, int unsigned xl,
                                 int unsigned yf, int unsigned yl, int thr,
                                 int unsigned budget);
      write_reg(lpf3_pkg::CSR_IMAGE_WIDTH, with_junk(width, lpf3_pkg::WIDTH_REG_BITS));
      write_reg(lpf3_pkg::CSR_REGION_X_FIRST, with_junk(xf, lpf3_pkg::COORD_BITS));
      write_reg(lpf3_pkg::CSR_REGION_X_LAST, with_junk(xl, lpf3_pkg::COORD_BITS));
      write_reg(lpf3_pkg::CSR_REGION_Y_FIRST, with_junk(yf, lpf3_pkg::COORD_BITS));
      write_reg(lpf3_pkg::CSR_REGION_Y_LAST, with_junk(yl, lpf3_pkg::COORD_BITS));
      write_reg(lpf3_pkg::CSR_PEAK_THRESHOLD, lpf3_pkg::CSR_DATA_BITS'(thr));
      write_reg(lpf3_pkg::CSR_PEAK_BUDGET, with_junk(budget, lpf3_pkg::SLOT_BITS));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic directed_frames();
      int unsigned k;
      // reset settings: a two-pixel frame only reports the default budget
      send_pixel(16'h7FFF, 1'b0);
      send_pixel(16'h8000, 1'b1);
      drain_block();
      // all ties at the lowest value; the final pixel finishes the window: peak, then summary
      apply_settings(3, 1, 1, 1, 1, -32768, 1);
      for (k = 1; k <= 9; k++) send_pixel(16'h8000, k == 9);
      drain_block();
      // width below the minimum, top threshold, no budget: the one peak sets overflow
      apply_settings(0, 1, 1, 1, 1, 32767, 0);
      for (k = 1; k <= 9; k++) send_pixel(16'h7FFF, k == 9);
   endtask

   task automatic random_frame();
      int unsigned width, w, rows, count, xf, xl, yf, yl, budget, full;
      int base, spread, thr, roll, pick;
      roll = $urandom_range(99, 0);
      width = (roll < 6) ? $urandom_range(2, 0) : $urandom_range(12, 3);
      w = (width < lpf3_pkg::MIN_WIDTH) ? lpf3_pkg::MIN_WIDTH : width;
      rows = $urandom_range(8, 3);
      xf = $urandom_range(w - 1, 0);
      xl = $urandom_range(w, xf);
      yf = $urandom_range(rows - 1, 0);
      yl = $urandom_range(rows, yf);
      // empty regions, widest legal bounds and all-ones bounds now and then
      roll = $urandom_range(99, 0);
      if (roll < 10) begin
         xf = xl + $urandom_range(3, 1);
      end else if (roll < 15) begin
         yf = yl + $urandom_range(3, 1);
      end else if (roll < 20) begin
         xf = 1;
         xl = 2046;
         yf = 1;
         yl = 2046;
      end else if (roll < 24) begin
         xf = 0;
         xl = 2047;
         yf = 0;
         yl = 2047;
      end
      roll = $urandom_range(99, 0);
      if (roll < 70) spread = $urandom_range(3, 0);
      else if (roll < 90) spread = $urandom_range(40, 4);
      else spread = $urandom_range(20000, 1000);
      roll = $urandom_range(99, 0);
      if (roll < 12) begin
         base = -32768;
      end else if (roll < 24) begin
         base = 32767 - spread;
      end else begin
         pick = $urandom_range(65535 - spread, 0);
         base = pick - 32768;
      end
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
         thr = -32768;
      end else if (roll < 14) begin
         thr = 32767;
      end else begin
         pick = $urandom_range(spread + 1, 0);
         thr = clamp_sample(base + pick - 1);
      end
      roll = $urandom_range(99, 0);
      if (roll < 30) budget = $urandom_range(2, 0);
      else if (roll < 80) budget = $urandom_range(20, 3);
      else if (roll < 88) budget = 4095;
      else budget = $urandom_range(4095, 0);
      // mostly whole frames, some cut mid-row, some running into an extra row
      full = w * rows;
      roll = $urandom_range(99, 0);
      if (roll < 70) count = full;
      else if (roll < 85) count = full - $urandom_range(w, 1);
      else count = full + $urandom_range(w, 1);
      drain_block();
      apply_settings(width, xf, xl, yf, yl, thr, budget);
      req_steady = ($urandom_range(3, 0) == 0);
      rsp_steady = ($urandom_range(3, 0) == 0);
      send_frame(count, base, spread);
      random_pixels += count;
   endtask

   // Single-pixel frames, one summary each, while the receiver holds off.
   task automatic fill_and_hold();
      int k;
      req_steady = 1'b1;
      holds_requested++;
      for (k = 0; k < PRESSURE_FRAMES; k++) send_pixel(pick_pixel(0, 100), 1'b1);
   endtask

   task automatic long_frames();
      // widths above the line store depth act as the full depth: a short frame stays in row 0
      drain_block();
      apply_settings($urandom_range(4095, 2049), 1, 2046, 1, 2046, -32768,
                     $urandom_range(6, 0));
      req_steady = 1'b1;
      send_frame(WIDE_PIXELS, 0, 1);
   endtask

   // Receiver: random stalls, plus one long hold-off when asked.
   initial begin : result_side
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (holds_requested != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            holds_done++;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            stall = pick_gap(rsp_steady);
         end
      end
   end

   // Check each accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.take_result(lpf3_pkg::result_type'({rsp_result_kind, rsp_peak_x,
                                                     rsp_peak_y, rsp_slots_left,
                                                     rsp_overflowed, rsp_last}));
   end

   // End the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
         $display("local_peak_finder_3x3 verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int frame_count;
      frame_count = 0;
      tracker = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_frames();
      while (random_pixels < RANDOM_PIXELS) begin
         random_frame();
         frame_count++;
         if (frame_count == 8) fill_and_hold();
      end
      long_frames();
      drain_block();
      tracker.close_out();
      $display("covered %0d pixels in %0d frames, widths 3 to 12 and one clamped, rows up to %0d",
               tracker.pixels_taken, tracker.summaries_seen, tracker.deepest_row);
      $display("checked %0d peaks and %0d summaries, %0d frames overflowed, %0d mismatches",
               tracker.peaks_seen, tracker.summaries_seen, tracker.overflowed_frames,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("local_peak_finder_3x3 verification clean");
      end else begin
         $display("local_peak_finder_3x3 verification failed");
      end
      $finish;
   end

endmodule
